// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the byte parser and word queue RTL files.
// Each macro expands to a labeled concurrent assertion in simulation
// and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Assert a property on the rising clock edge, off while reset is low.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Assert that an expression never holds while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== hw/rtl/eafd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEG ADC frame deframer package
// Payload types, queue entry and status types, and shared constants.
// ----------------------------------------------------------------------------
package eafd_pkg;

    localparam int unsigned CHANNELS_PER_DEVICE_DEF = 8;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned WORD_W  = 24;
    localparam int unsigned CH_W    = 4;
    localparam logic [POS_W-1:0] POS_IDLE = '1;

    // byte phase within a 24-bit word
    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_LAST  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } eafd_in_t;

    typedef struct packed {
        logic                     is_status;
        logic                     device_index;
        logic [CH_W-1:0]          channel_index;
        logic signed [WORD_W-1:0] sample;
        logic [WORD_W-1:0]        status_word;
        logic                     frame_end;
    } eafd_out_t;

    // one completed word, handed from the parser to the output stage
    typedef struct packed {
        logic              is_status;
        logic              device_index;
        logic [CH_W-1:0]   channel_index;
        logic [WORD_W-1:0] word;
        logic              frame_end;
    } eafd_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } eafd_qstat_t;

endpackage

// ===== hw/rtl/eafd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEG ADC frame deframer: byte parser
// Tracks the byte position in the frame, builds 24-bit words and pushes
// each completed status word or channel sample into the word queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eafd_front
    import eafd_pkg::*;
#(
    parameter int unsigned CHANNELS_PER_DEVICE = CHANNELS_PER_DEVICE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  eafd_in_t    s_data,
    input  eafd_qstat_t qstat,
    output logic        push,
    output eafd_word_t  push_data
);

    localparam int unsigned BLOCK_BYTES = 3 * (1 + CHANNELS_PER_DEVICE);
    localparam logic [POS_W-1:0] LEN_ONE = POS_W'(BLOCK_BYTES);
    localparam logic [POS_W-1:0] LEN_TWO = POS_W'(2 * BLOCK_BYTES);
    localparam int unsigned WCNT_W = $clog2(CHANNELS_PER_DEVICE + 1);
    localparam logic [WCNT_W-1:0] WORD_LAST = WCNT_W'(CHANNELS_PER_DEVICE);
    localparam logic [CH_W-1:0]   DEV1_BASE = CH_W'(CHANNELS_PER_DEVICE);

    logic              daisy_reg;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [1:0]        phase_reg, phase_next;
    logic [WCNT_W-1:0] word_reg,  word_next;
    logic              dev_reg,   dev_next;
    logic [WORD_W-1:0] acc_reg,   acc_next;

    logic [POS_W-1:0]  pos_eff;
    logic [1:0]        phase_eff;
    logic [WCNT_W-1:0] word_eff;
    logic              dev_eff;
    logic [POS_W-1:0]  frame_len;
    logic              accept;
    logic              active;

    assign s_ready   = !qstat.full;
    assign accept    = s_valid && s_ready;
    assign frame_len = daisy_reg ? LEN_TWO : LEN_ONE;

    // a frame start restarts the count before the byte is taken
    assign pos_eff   = s_data.frame_start ? '0 : pos_reg;
    assign phase_eff = s_data.frame_start ? PHASE_FIRST : phase_reg;
    assign word_eff  = s_data.frame_start ? '0 : word_reg;
    assign dev_eff   = s_data.frame_start ? 1'b0 : dev_reg;

    assign active = accept && (pos_eff < frame_len);
    assign push   = active && (phase_eff == PHASE_LAST);

    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        word_next  = word_reg;
        dev_next   = dev_reg;
        acc_next   = acc_reg;
        if (active) begin
            pos_next = pos_eff + POS_W'(1);
            acc_next = {acc_reg[WORD_W-9:0], s_data.data_byte};
            word_next = word_eff;
            dev_next  = dev_eff;
            if (phase_eff == PHASE_LAST) begin
                phase_next = PHASE_FIRST;
                // wrap to the next device block after its last channel
                if (word_eff == WORD_LAST) begin
                    word_next = '0;
                    dev_next  = !dev_eff;
                end else begin
                    word_next = word_eff + WCNT_W'(1);
                end
            end else begin
                phase_next = phase_eff + 2'd1;
            end
        end
    end

    always_comb begin
        push_data.is_status     = (word_eff == '0);
        push_data.device_index  = dev_eff;
        push_data.word          = acc_next;
        push_data.channel_index = '0;
        push_data.frame_end     = 1'b0;
        if (word_eff != '0) begin
            push_data.channel_index = (dev_eff ? DEV1_BASE : CH_W'(0))
                                    + CH_W'(word_eff) - CH_W'(1);
            push_data.frame_end     = (pos_eff + POS_W'(1) == frame_len);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            daisy_reg <= 1'b0;
            pos_reg   <= POS_IDLE;
            phase_reg <= PHASE_FIRST;
            word_reg  <= '0;
            dev_reg   <= 1'b0;
            acc_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                daisy_reg <= cfg_wr_data;
            end
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            word_reg  <= word_next;
            dev_reg   <= dev_next;
            acc_reg   <= acc_next;
        end
    end

    `ASSERT_PROP(a_pos_bounded, aclk, aresetn,
        (pos_reg == POS_IDLE) || (pos_reg <= LEN_TWO))
    `ASSERT_NEVER(a_status_no_end, aclk, aresetn,
        push && push_data.is_status && push_data.frame_end)

endmodule

// ===== hw/rtl/eafd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEG ADC frame deframer: word queue
// Two-entry queue that decouples the byte parser from the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eafd_queue
    import eafd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  eafd_word_t  push_data,
    input  logic        pop,
    output eafd_word_t  pop_data,
    output eafd_qstat_t qstat
);

    localparam int unsigned DEPTH = 2;

    eafd_word_t mem [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push, do_pop;

    assign qstat.full  = (count_reg == 2'(DEPTH));
    assign qstat.empty = (count_reg == 2'd0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_data    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_PROP(a_count_bounded, aclk, aresetn, count_reg <= 2'(DEPTH))
    `ASSERT_PROP(a_push_grows, aclk, aresetn,
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))

endmodule

// ===== hw/rtl/eafd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEG ADC frame deframer: output stage
// Takes words from the queue and formats them into result requests held
// in an output register until the receiver takes them.
// ----------------------------------------------------------------------------
module eafd_back
    import eafd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  eafd_qstat_t qstat,
    input  eafd_word_t  pop_data,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output eafd_out_t   m_data
);

    logic      m_valid_reg, m_valid_next;
    eafd_out_t m_data_reg,  m_data_next;
    eafd_out_t fmt;

    // zero the fields that do not belong to the word kind
    always_comb begin
        fmt.is_status     = pop_data.is_status;
        fmt.device_index  = pop_data.device_index;
        fmt.channel_index = pop_data.channel_index;
        fmt.frame_end     = pop_data.frame_end;
        if (pop_data.is_status) begin
            fmt.sample      = '0;
            fmt.status_word = pop_data.word;
        end else begin
            fmt.sample      = signed'(pop_data.word);
            fmt.status_word = '0;
        end
    end

    assign pop = !qstat.empty && (!m_valid_reg || m_ready);

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_data_next  = fmt;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/eeg_adc_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEG ADC frame deframer
// Parses the read-data byte stream of a chained biopotential converter
// into status words and signed 24-bit channel samples.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_data) carries one received byte per
// request, with frame_start marking the first byte of a frame. A frame
// is one device block, or two when daisy_chain is set; each block is a
// 3-byte status word and CHANNELS_PER_DEVICE 24-bit samples.
// Result channel (m_valid/m_ready/m_data) carries one request per third
// frame byte: a status word or a channel sample, frame_end on the last.
// Bytes past the end of a frame are dropped until the next frame_start.
// Throughput: one byte per cycle while s_ready is high. A completed word
// passes through the queue and then the output register to m_valid.
// A two-entry word queue sits between the parser and the output register;
// when the receiver stalls the queue fills and s_ready drops.
// Write daisy_chain through cfg_wr_en/cfg_wr_data while the block is idle.
// Reset clears daisy_chain and leaves the parser idle awaiting frame_start.
// ----------------------------------------------------------------------------
module eeg_adc_frame_deframer_top
    import eafd_pkg::*;
#(
    parameter int unsigned CHANNELS_PER_DEVICE = CHANNELS_PER_DEVICE_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  eafd_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output eafd_out_t m_data
);

    eafd_qstat_t qstat;
    logic        push;
    logic        pop;
    eafd_word_t  push_data;
    eafd_word_t  pop_data;

    eafd_front #(
        .CHANNELS_PER_DEVICE(CHANNELS_PER_DEVICE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .qstat       (qstat),
        .push        (push),
        .push_data   (push_data)
    );

    eafd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    eafd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== verif/eeg_adc_frame_deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEG ADC frame deframer checker
// Watches the byte and word channels and the chain register port. For each
// accepted byte it parses the frame on its own and queues the word that the
// byte completes. Each word leaving the block is compared, field by field,
// with the oldest queued word.
// ----------------------------------------------------------------------------
module eeg_adc_frame_deframer_checker
    import eafd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  eafd_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  eafd_out_t   m_data,
    output int unsigned n_pending,
    output int unsigned n_errors,
    output int unsigned n_words,
    output int unsigned n_frame_ends
);

    localparam int unsigned BLOCK_LEN = 3 * (1 + CHANNELS_PER_DEVICE_DEF);

    logic             chain_on;
    logic [POS_W-1:0] frame_pos;
    logic [WORD_W-1:0] shift_acc;
    eafd_out_t        words_q[$];
    int unsigned      err_cnt;
    int unsigned      word_cnt;
    int unsigned      end_cnt;

    initial begin
        n_pending    = 0;
        n_errors     = 0;
        n_words      = 0;
        n_frame_ends = 0;
        err_cnt      = 0;
        word_cnt     = 0;
        end_cnt      = 0;
    end

    // Advance the frame parser by one byte; return 1 when a word completes.
    function automatic bit parse_byte(input eafd_in_t item, output eafd_out_t word);
        int unsigned flen;
        int unsigned pos;
        int unsigned dev;
        int unsigned slot;
        word = '0;
        flen = chain_on ? 2 * BLOCK_LEN : BLOCK_LEN;
        if (item.frame_start) begin
            frame_pos = '0;
        end
        if (frame_pos >= flen) begin
            return 1'b0;
        end
        pos       = frame_pos;
        shift_acc = {shift_acc[WORD_W-9:0], item.data_byte};
        frame_pos = frame_pos + 1'b1;
        if (pos % 3 != PHASE_LAST) begin
            return 1'b0;
        end
        dev  = pos / BLOCK_LEN;
        slot = (pos % BLOCK_LEN) / 3;
        word.device_index = dev[0];
        if (slot == 0) begin
            word.is_status   = 1'b1;
            word.status_word = shift_acc;
        end else begin
            word.channel_index = CH_W'(dev * CHANNELS_PER_DEVICE_DEF + slot - 1);
            word.sample        = shift_acc;
            word.frame_end     = (pos + 1 == flen);
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        eafd_out_t want;
        if (!aresetn) begin
            chain_on  = 1'b0;
            frame_pos = POS_IDLE;
            shift_acc = '0;
            words_q.delete();
        end else begin
            if (cfg_wr_en) begin
                chain_on = cfg_wr_data;
            end
            if (s_valid && s_ready && parse_byte(s_data, want)) begin
                words_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (words_q.size() == 0) begin
                    $error("word request with nothing pending: 0x%0h", m_data);
                    err_cnt++;
                end else begin
                    want = words_q.pop_front();
                    check_field("is_status", WORD_W'(want.is_status),
                                WORD_W'(m_data.is_status));
                    check_field("device_index", WORD_W'(want.device_index),
                                WORD_W'(m_data.device_index));
                    check_field("channel_index", WORD_W'(want.channel_index),
                                WORD_W'(m_data.channel_index));
                    check_field("sample", want.sample, m_data.sample);
                    check_field("status_word", want.status_word, m_data.status_word);
                    check_field("frame_end", WORD_W'(want.frame_end),
                                WORD_W'(m_data.frame_end));
                    word_cnt++;
                    if (want.frame_end) begin
                        end_cnt++;
                    end
                end
            end
        end
        n_pending    <= words_q.size();
        n_errors     <= err_cnt;
        n_words      <= word_cnt;
        n_frame_ends <= end_cnt;
    end

endmodule

// ===== verif/eeg_adc_frame_deframer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEG ADC frame deframer testbench
// Feeds single and chained frames, restarts, truncated frames, trailing
// bytes and mid-frame chain changes, under random sender and receiver
// gaps and one long receiver stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
module eeg_adc_frame_deframer_top_test;
    import eafd_pkg::*;

    localparam int unsigned BLOCK_LEN      = 3 * (1 + CHANNELS_PER_DEVICE_DEF);
    localparam int unsigned RANDOM_BYTES   = 850;
    localparam int unsigned PHASE_BYTES    = 60;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned RX_HOLD_CYCLES = 150;

    localparam logic [7:0] CORNER_FRAME [BLOCK_LEN] = '{
        8'hFF, 8'hFF, 8'hFF,  8'h80, 8'h00, 8'h00,  8'h7F, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00,  8'hFF, 8'hFF, 8'hFF,  8'h00, 8'h00, 8'h01,
        8'h80, 8'h00, 8'h01,  8'h55, 8'hAA, 8'h55,  8'hAA, 8'h55, 8'hAA
    };

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    eafd_in_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    eafd_out_t m_data;

    int unsigned n_pending;
    int unsigned n_errors;
    int unsigned n_words;
    int unsigned n_frame_ends;

    int unsigned src_idle_pct = 20;
    int unsigned dst_idle_pct = 61;
    logic        rx_hold_req  = 1'b0;
    logic        chain_on     = 1'b0;
    int unsigned n_bytes      = 0;
    int unsigned n_cfg        = 0;

    always #1 aclk = ~aclk;

    eeg_adc_frame_deframer_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    eeg_adc_frame_deframer_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .n_pending    (n_pending),
        .n_errors     (n_errors),
        .n_words      (n_words),
        .n_frame_ends (n_frame_ends)
    );

    // Receiver: random back-pressure, or a long hold-off when requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req <= 1'b0;
                m_ready     <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: value, frame_start: start};
        do @(posedge aclk); while (!s_ready);
        n_bytes++;
    endtask

    // Stop offering and wait until every queued word has left the block.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (n_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_chain(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        chain_on  = value;
        n_cfg++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random frame content; a rare stray frame_start restarts mid-frame.
    task automatic send_frame(input bit with_start, input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(pick_byte(), (i == 0 && with_start) || ($urandom_range(99) == 0));
        end
    endtask

    initial begin
        int unsigned rnd_bytes;
        int unsigned phase_bytes;
        int unsigned flen;
        int unsigned len;
        int unsigned pick;
        int unsigned mode;
        bit          first;
        rnd_bytes = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_chain(1'b0);

        // idle after reset, then a restart over a partial frame
        send_byte(8'hA5, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        for (int unsigned i = 0; i < BLOCK_LEN; i++) begin
            send_byte(CORNER_FRAME[i], i == 0);
        end
        // past the end of the frame: drop
        send_byte(8'hFF, 1'b0);
        drain();

        // fill the block while the receiver holds off
        write_chain(1'b1);
        rx_hold_req <= 1'b1;
        send_frame(1'b1, 2 * BLOCK_LEN);
        drain();

        // shorten the frame below the bytes consumed, then lengthen a done one
        send_frame(1'b1, 40);
        drain();
        write_chain(1'b0);
        send_frame(1'b0, 3);
        send_frame(1'b1, BLOCK_LEN);
        drain();
        write_chain(1'b1);
        send_frame(1'b0, BLOCK_LEN);
        rnd_bytes = 2 * BLOCK_LEN + 40 + 2 * BLOCK_LEN;

        while (rnd_bytes < RANDOM_BYTES) begin
            mode = rnd_bytes * 3 / RANDOM_BYTES;
            case (mode)
                0: begin
                    src_idle_pct = 20;
                    dst_idle_pct = 61;
                end
                1: begin
                    src_idle_pct = 61;
                    dst_idle_pct = 20;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            drain();
            write_chain(($urandom_range(3) == 0) ? chain_on : ~chain_on);
            phase_bytes = 0;
            first       = 1'b1;
            while (phase_bytes < PHASE_BYTES) begin
                flen = chain_on ? 2 * BLOCK_LEN : BLOCK_LEN;
                pick = $urandom_range(9);
                if (pick < 8) begin
                    len = flen;
                end else if (pick == 8) begin
                    len = $urandom_range(flen - 1, 1);
                end else begin
                    len = flen + $urandom_range(4, 1);
                end
                // now and then carry on the previous frame across the phase change
                send_frame(!(first && $urandom_range(9) == 0), len);
                phase_bytes += (len < flen) ? len : flen;
                first = 1'b0;
            end
            rnd_bytes += phase_bytes;
        end

        drain();
        $display("Sent %0d bytes over %0d chain settings; checked %0d words, %0d frame ends.",
                 n_bytes, n_cfg, n_words, n_frame_ends);
        $display("Covered restarts, truncated and overlong frames, chain changes mid-frame.");
        if (n_errors == 0 && n_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
